[rtl/tlsm_pkg.sv]
// shared constants, types and tier lookup functions for the tiered lift setpoint manager
`timescale 1ns / 1ps
`default_nettype none

package tlsm_pkg;

  localparam int unsigned TierCount = 6;
  localparam int unsigned HeightW   = 16;
  localparam int unsigned TierW     = 3;
  localparam int unsigned KindW     = 3;
  localparam int unsigned SpeedW    = 9;
  localparam int unsigned ReqW      = 4;
  localparam int unsigned RegCount  = 7;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 24;

  typedef logic [HeightW-1:0] height_t;
  typedef logic [TierW-1:0]   tier_t;
  typedef logic [TierCount-1:0][HeightW-1:0] tiers_t;

  // command kinds
  localparam logic [KindW-1:0] KindRaise    = 3'd0;
  localparam logic [KindW-1:0] KindLower    = 3'd1;
  localparam logic [KindW-1:0] KindStop     = 3'd2;
  localparam logic [KindW-1:0] KindTierUp   = 3'd3;
  localparam logic [KindW-1:0] KindTierDown = 3'd4;
  localparam logic [KindW-1:0] KindSetTier  = 3'd5;

  // register indexes
  localparam logic [2:0] RegTier0   = 3'd0;
  localparam logic [2:0] RegTier5   = 3'd5;
  localparam logic [2:0] RegMaxStep = 3'd6;

  localparam tier_t   TopTier   = 3'd5;
  localparam logic [SpeedW-1:0] FullSpeed = 9'd256;

  localparam tiers_t TierReset = {16'd12800, 16'd10240, 16'd7680,
                                  16'd5120, 16'd2560, 16'd768};
  localparam height_t MaxStepReset = 16'd256;

  // tier holding h, strict < bounds on tiers one to five
  function automatic tier_t tier_strict(input height_t h, input tiers_t th);
    tier_t r;
    r = TopTier;
    for (int i = TierCount - 1; i >= 1; i--) begin
      if (h < th[i]) r = tier_t'(i - 1);
    end
    return r;
  endfunction

  // same search with <= bounds
  function automatic tier_t tier_le(input height_t h, input tiers_t th);
    tier_t r;
    r = TopTier;
    for (int i = TierCount - 1; i >= 1; i--) begin
      if (h <= th[i]) r = tier_t'(i - 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/tiered_lift_setpoint_manager_unit.sv]
// top level of the tiered lift setpoint manager: command stream in, setpoint stream out
`timescale 1ns / 1ps
`default_nettype none

// Keeps a lift target height and target tier against six tier heights set over the
// APB port (index 0..5 at byte addresses 0x00..0x14, max_step at 0x18). Each command
// request on the slave stream gives exactly one result on the master stream. A request
// is taken every cycle while the input register is empty or can pass its command on;
// the input register holds the command with its step (speed times max_step, divided by
// 256) already multiplied, and the result register takes the new target state once the
// master stream is not stalled. Write configuration only while no request is in flight.
module tiered_lift_setpoint_manager_unit (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // apb configuration
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire  [tlsm_pkg::AddrW-1:0]      paddr,
  input  wire  [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // command stream
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  // speed[8:0], requested_tier[12:9], measured_position[28:13], zero pad[31:29]
  input  wire  [tlsm_pkg::InDataW-1:0]    s_axis_tdata,
  // kind[2:0]
  input  wire  [tlsm_pkg::KindW-1:0]      s_axis_tuser,
  // result stream
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  // setpoint[15:0], target_tier[18:16], measured_tier[21:19], at_top[22], zero pad[23]
  output logic [tlsm_pkg::OutDataW-1:0]   m_axis_tdata
);
  import tlsm_pkg::*;

  // configuration registers
  tiers_t  tiers_q;
  height_t max_step_q;
  logic [2:0] reg_idx;
  logic    cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tiers_q    <= TierReset;
      max_step_q <= MaxStepReset;
    end else if (cfg_wr) begin
      if (reg_idx <= RegTier5) tiers_q[reg_idx] <= pwdata[HeightW-1:0];
      else if (reg_idx == RegMaxStep) max_step_q <= pwdata[HeightW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx <= RegTier5) prdata = {16'd0, tiers_q[reg_idx]};
    else if (reg_idx == RegMaxStep) prdata = {16'd0, max_step_q};
  end

  // input stage
  logic [SpeedW-1:0]   in_speed;
  logic [ReqW-1:0]     in_req;
  height_t             in_meas;
  logic [SpeedW-1:0]   speed_sat;
  logic [24:0]         step_prod;

  assign in_speed  = s_axis_tdata[8:0];
  assign in_req    = s_axis_tdata[12:9];
  assign in_meas   = s_axis_tdata[28:13];
  assign speed_sat = (in_speed > FullSpeed) ? FullSpeed : in_speed;
  assign step_prod = {16'd0, speed_sat} * {9'd0, max_step_q};

  logic              a_valid_q;
  logic [KindW-1:0]  a_kind_q;
  height_t           a_step_q;
  logic [ReqW-1:0]   a_req_q;
  height_t           a_meas_q;
  logic              out_adv;
  logic              a_load;

  assign out_adv       = a_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !a_valid_q || out_adv;
  assign a_load        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      a_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_kind_q <= s_axis_tuser;
      a_step_q <= step_prod[23:8];
      a_req_q  <= in_req;
      a_meas_q <= in_meas;
    end
  end

  // target update
  height_t      target_h_q, target_h_d;
  tier_t        target_i_q, target_i_d;
  logic [16:0]  raise_sum;
  logic [17:0]  lower_diff;
  height_t      raise_h, lower_h;
  tier_t        jump_tier;
  logic         do_jump;

  assign raise_sum  = {1'b0, target_h_q} + {1'b0, a_step_q};
  assign lower_diff = {2'b00, target_h_q} - {2'b00, a_step_q};
  assign raise_h    = (raise_sum > {1'b0, tiers_q[TopTier]}) ? tiers_q[TopTier]
                                                             : raise_sum[HeightW-1:0];
  // negative differences fall below any tier height
  assign lower_h    = ($signed(lower_diff) < $signed({2'b00, tiers_q[RegTier0]}))
                      ? tiers_q[RegTier0] : lower_diff[HeightW-1:0];

  always_comb begin
    target_h_d = target_h_q;
    target_i_d = target_i_q;
    jump_tier  = target_i_q;
    do_jump    = 1'b0;
    case (a_kind_q)
      KindRaise: begin
        target_h_d = raise_h;
        target_i_d = tier_strict(raise_h, tiers_q);
      end
      KindLower: begin
        target_h_d = lower_h;
        target_i_d = tier_strict(lower_h, tiers_q);
      end
      KindStop: begin
        target_h_d = a_meas_q;
      end
      KindTierUp: begin
        do_jump   = 1'b1;
        jump_tier = (target_i_q >= TopTier) ? TopTier : target_i_q + tier_t'(1);
      end
      KindTierDown: begin
        do_jump   = 1'b1;
        jump_tier = tier_le(target_h_q, tiers_q);
      end
      KindSetTier: begin
        do_jump = 1'b1;
        if (a_req_q[ReqW-1]) jump_tier = '0;
        else if (a_req_q[2:0] > TopTier) jump_tier = TopTier;
        else jump_tier = a_req_q[2:0];
      end
      default: begin
      end
    endcase
    if (do_jump) begin
      target_i_d = jump_tier;
      target_h_d = tiers_q[jump_tier];
    end
  end

  // measured position reports
  tier_t        meas_tier_q;
  logic         at_top_q;
  logic [21:0]  meas_x50, top_x49;

  assign meas_x50 = {6'd0, a_meas_q} * 22'd50;
  assign top_x49  = {6'd0, tiers_q[TopTier]} * 22'd49;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_h_q    <= '0;
      target_i_q    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_adv) begin
        target_h_q <= target_h_d;
        target_i_q <= target_i_d;
      end
      if (!m_axis_tvalid || m_axis_tready) m_axis_tvalid <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      meas_tier_q <= tier_strict(a_meas_q, tiers_q);
      at_top_q    <= meas_x50 > top_x49;
    end
  end

  // the state registers double as the result payload
  assign m_axis_tdata = {1'b0, at_top_q, meas_tier_q, target_i_q, target_h_q};

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// self-checking testbench for the tiered lift setpoint manager unit
`timescale 1ns / 1ps

module testbench;
  import tlsm_pkg::*;

  localparam logic [KindW-1:0] KindSpare6 = 3'd6;
  localparam logic [KindW-1:0] KindSpare7 = 3'd7;
  localparam int unsigned PhaseCount  = 8;
  localparam int unsigned RandomItems = 210;
  localparam int unsigned CycleLimit  = 400000;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [SpeedW-1:0] speed;
    logic [ReqW-1:0]   req_tier;
    height_t           position;
  } lift_cmd_t;

  typedef struct packed {
    height_t setpoint;
    tier_t   target_tier;
    tier_t   meas_tier;
    logic    at_top;
  } lift_result_t;

  // one directed request, with its result typed in where typed is set
  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [SpeedW-1:0] speed;
    logic [ReqW-1:0]   req_tier;
    height_t           position;
    logic              typed;
    height_t           setpoint;
    tier_t             target_tier;
    tier_t             meas_tier;
    logic              at_top;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [KindW-1:0]    s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // predictor state and configuration
  tiers_t  tier_h;
  height_t lift_step;
  height_t tgt_height;
  tier_t   tgt_tier;

  lift_result_t setpoint_q[$];
  dir_row_t     dir_table [22];
  int           errors = 0;
  int           results_checked = 0;
  int           commands_sent = 0;
  int           kind_seen [8];
  int           cycle_count = 0;
  int           sink_stall_left = 0;
  bit           src_idle_on = 1'b1;
  bit           sink_idle_on = 1'b1;

  tiered_lift_setpoint_manager_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("%0t: no progress after %0d cycles", $time, cycle_count);
    $display("tiered_lift_setpoint_manager_unit test failed");
    $finish;
  end

  // tier under the first bound above h, inclusive picks <= instead of <
  function automatic tier_t tier_under(input int unsigned h, input bit inclusive);
    for (int i = 1; i < TierCount; i++) begin
      if (inclusive ? (h <= tier_h[i]) : (h < tier_h[i])) return tier_t'(i - 1);
    end
    return TopTier;
  endfunction

  // advances the target state by one command and returns the result it reports
  function automatic lift_result_t apply_command(input lift_cmd_t c);
    lift_result_t r;
    int unsigned  spd, stp, up, pos50, top49;
    int           down, req;
    spd = (c.speed > FullSpeed) ? FullSpeed : c.speed;
    stp = (spd * lift_step) >> 8;
    case (c.kind)
      KindRaise: begin
        up = tgt_height + stp;
        tgt_height = (up > tier_h[TopTier]) ? tier_h[TopTier] : height_t'(up);
        tgt_tier = tier_under(tgt_height, 1'b0);
      end
      KindLower: begin
        down = int'(tgt_height) - int'(stp);
        if (down < int'(tier_h[0])) down = int'(tier_h[0]);
        tgt_height = height_t'(down);
        tgt_tier = tier_under(tgt_height, 1'b0);
      end
      KindStop: tgt_height = c.position;
      KindTierUp: begin
        tgt_tier = (tgt_tier >= TopTier) ? TopTier : tier_t'(tgt_tier + 1);
        tgt_height = tier_h[tgt_tier];
      end
      KindTierDown: begin
        tgt_tier = tier_under(tgt_height, 1'b1);
        tgt_height = tier_h[tgt_tier];
      end
      KindSetTier: begin
        req = int'($signed(c.req_tier));
        if (req < 0) req = 0;
        if (req > int'(TopTier)) req = int'(TopTier);
        tgt_tier = tier_t'(req);
        tgt_height = tier_h[tgt_tier];
      end
      default: ;
    endcase
    pos50 = c.position * 50;
    top49 = tier_h[TopTier] * 49;
    r.setpoint = tgt_height;
    r.target_tier = tgt_tier;
    r.meas_tier = tier_under(c.position, 1'b0);
    r.at_top = (pos50 > top49);
    return r;
  endfunction

  task automatic send_command(input lift_cmd_t c, input bit typed, input lift_result_t typed_res);
    lift_result_t r;
    if (src_idle_on && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, c.position, c.req_tier, c.speed};
    s_axis_tuser <= c.kind;
    do @(posedge clk_i); while (!s_axis_tready);
    r = apply_command(c);
    setpoint_q.push_back(typed ? typed_res : r);
    kind_seen[c.kind]++;
    commands_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input height_t value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'({idx, 2'b00});
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    if (idx == RegMaxStep) lift_step = value;
    else tier_h[idx] = value;
  endtask

  task automatic report_field(input string name, input int unsigned want, input int unsigned got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
  endtask

  // sink side: random stall bursts
  always @(posedge clk_i) begin
    if (sink_stall_left != 0) sink_stall_left--;
    else if (sink_idle_on && $urandom_range(0, 99) < 10) sink_stall_left = $urandom_range(1, 17);
    m_axis_tready <= (sink_stall_left == 0);
  end

  always @(posedge clk_i) begin
    lift_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.setpoint = m_axis_tdata[15:0];
      got.target_tier = m_axis_tdata[18:16];
      got.meas_tier = m_axis_tdata[21:19];
      got.at_top = m_axis_tdata[22];
      if (setpoint_q.size() == 0) begin
        errors++;
        $display("%0t: result %h with no request pending", $time, m_axis_tdata);
      end else begin
        want = setpoint_q.pop_front();
        results_checked++;
        if (got.setpoint !== want.setpoint)
          report_field("setpoint", want.setpoint, got.setpoint);
        if (got.target_tier !== want.target_tier)
          report_field("target_tier", want.target_tier, got.target_tier);
        if (got.meas_tier !== want.meas_tier)
          report_field("measured_tier", want.meas_tier, got.meas_tier);
        if (got.at_top !== want.at_top)
          report_field("at_top", want.at_top, got.at_top);
      end
    end
  end

  initial begin
    lift_cmd_t    cmd;
    lift_result_t res;
    tiers_t       new_tiers;
    height_t      new_step;
    int           acc, spacing, thr, pick;

    tier_h = TierReset;
    lift_step = MaxStepReset;
    tgt_height = '0;
    tgt_tier = '0;
    foreach (kind_seen[k]) kind_seen[k] = 0;

    // kind, speed, tier, position, typed, setpoint, target tier, measured tier, at top
    dir_table = '{
      '{KindRaise,    9'd0,   4'd0,    16'd0,     1'b1, 16'd0,     3'd0, 3'd0, 1'b0},
      '{KindLower,    9'd256, 4'd0,    16'd65535, 1'b1, 16'd768,   3'd0, 3'd5, 1'b1},
      // saturated speed, position right on the at-top threshold
      '{KindRaise,    9'd511, 4'd0,    16'd12544, 1'b1, 16'd1024,  3'd0, 3'd4, 1'b0},
      '{KindRaise,    9'd256, 4'd0,    16'd12545, 1'b1, 16'd1280,  3'd0, 3'd4, 1'b1},
      '{KindSetTier,  9'd0,   4'd7,    16'd12800, 1'b1, 16'd12800, 3'd5, 3'd5, 1'b1},
      '{KindRaise,    9'd256, 4'd0,    16'd2559,  1'b1, 16'd12800, 3'd5, 3'd0, 1'b0},
      '{KindTierUp,   9'd0,   4'd0,    16'd2560,  1'b1, 16'd12800, 3'd5, 3'd1, 1'b0},
      // negative tiers clamp to the bottom
      '{KindSetTier,  9'd0,   4'b1000, 16'd0,     1'b1, 16'd768,   3'd0, 3'd0, 1'b0},
      '{KindSetTier,  9'd0,   4'b1111, 16'd5119,  1'b1, 16'd768,   3'd0, 3'd1, 1'b0},
      '{KindSetTier,  9'd0,   4'd3,    16'd5120,  1'b1, 16'd7680,  3'd3, 3'd2, 1'b0},
      '{KindTierDown, 9'd0,   4'd0,    16'd7680,  1'b1, 16'd5120,  3'd2, 3'd3, 1'b0},
      '{KindTierUp,   9'd0,   4'd0,    16'd10240, 1'b1, 16'd7680,  3'd3, 3'd4, 1'b0},
      '{KindStop,     9'd0,   4'd0,    16'd9000,  1'b1, 16'd9000,  3'd3, 3'd3, 1'b0},
      '{KindTierDown, 9'd0,   4'd0,    16'd65535, 1'b1, 16'd7680,  3'd3, 3'd5, 1'b1},
      '{KindLower,    9'd128, 4'd0,    16'd100,   1'b1, 16'd7552,  3'd2, 3'd0, 1'b0},
      '{KindSpare6,   9'd0,   4'd0,    16'd10239, 1'b1, 16'd7552,  3'd2, 3'd3, 1'b0},
      '{KindSpare7,   9'd511, 4'd7,    16'd40000, 1'b1, 16'd7552,  3'd2, 3'd5, 1'b1},
      '{KindSetTier,  9'd0,   4'd5,    16'd12543, 1'b1, 16'd12800, 3'd5, 3'd4, 1'b0},
      '{KindRaise,    9'd1,   4'd0,    16'd0,     1'b1, 16'd12800, 3'd5, 3'd0, 1'b0},
      // tier down from exactly a tier height lands one below
      '{KindTierDown, 9'd0,   4'd0,    16'd0,     1'b1, 16'd10240, 3'd4, 3'd0, 1'b0},
      '{KindLower,    9'd255, 4'd0,    16'd0,     1'b1, 16'd9985,  3'd3, 3'd0, 1'b0},
      '{KindRaise,    9'd200, 4'd0,    16'd33333, 1'b0, 16'd0,     3'd0, 3'd0, 1'b0}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[n]) begin
      cmd = '{dir_table[n].kind, dir_table[n].speed, dir_table[n].req_tier,
              dir_table[n].position};
      res = '{dir_table[n].setpoint, dir_table[n].target_tier, dir_table[n].meas_tier,
              dir_table[n].at_top};
      send_command(cmd, dir_table[n].typed, res);
    end

    for (int ph = 0; ph < PhaseCount; ph++) begin
      s_axis_tvalid <= 1'b0;
      while (setpoint_q.size() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);

      case (ph)
        1: begin
          new_tiers = '0;
          new_step = '0;
        end
        2: begin
          new_tiers = '1;
          new_step = '1;
        end
        3, 5, 7: begin
          // ascending heights; tight spacing in phase five
          spacing = (ph == 5) ? 40 : 12000;
          acc = (ph == 5) ? $urandom_range(0, 65000) : $urandom_range(0, 2000);
          for (int i = 0; i < TierCount; i++) begin
            new_tiers[i] = height_t'((acc > 65535) ? 65535 : acc);
            acc += $urandom_range(0, spacing);
          end
          new_step = (ph == 5) ? 16'hFFFF : height_t'($urandom_range(0, 65535));
        end
        4: begin
          for (int i = 0; i < TierCount; i++) new_tiers[i] = height_t'($urandom_range(0, 65535));
          new_step = height_t'($urandom_range(0, 65535));
        end
        6: begin
          // bottom tier above the rest
          for (int i = 1; i < TierCount; i++) new_tiers[i] = height_t'($urandom_range(0, 65535));
          new_tiers[0] = 16'hFFFF;
          new_step = height_t'($urandom_range(0, 255));
        end
        default: begin
          new_tiers = TierReset;
          new_step = MaxStepReset;
        end
      endcase
      for (int i = 0; i < TierCount; i++) write_reg(RegTier0 + 3'(i), new_tiers[i]);
      write_reg(RegMaxStep, new_step);

      src_idle_on = (ph % 3 != 2) && (ph != PhaseCount - 1);
      sink_idle_on = (ph % 4 != 1) && (ph != PhaseCount - 1);

      repeat (RandomItems) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) cmd.kind = KindRaise;
        else if (pick < 40) cmd.kind = KindLower;
        else if (pick < 50) cmd.kind = KindStop;
        else if (pick < 63) cmd.kind = KindTierUp;
        else if (pick < 76) cmd.kind = KindTierDown;
        else if (pick < 92) cmd.kind = KindSetTier;
        else cmd.kind = ($urandom_range(0, 1) != 0) ? KindSpare7 : KindSpare6;
        case ($urandom_range(0, 3))
          0: cmd.speed = SpeedW'($urandom_range(0, 511));
          1: cmd.speed = FullSpeed;
          2: cmd.speed = SpeedW'($urandom_range(257, 511));
          default: cmd.speed = SpeedW'($urandom_range(0, 32));
        endcase
        cmd.req_tier = ReqW'($urandom_range(0, 15));
        // positions random, around tier bounds, around the at-top threshold or at the target height
        thr = (49 * int'(tier_h[TopTier])) / 50;
        case ($urandom_range(0, 3))
          0: cmd.position = height_t'($urandom_range(0, 65535));
          1: cmd.position = height_t'(int'(tier_h[$urandom_range(0, 5)]) +
                                      int'($urandom_range(0, 2)) - 1);
          2: cmd.position = height_t'(thr + int'($urandom_range(0, 4)) - 2);
          default: cmd.position = tgt_height;
        endcase
        send_command(cmd, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (setpoint_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d commands sent, %0d results checked over %0d config phases in %0d cycles",
             commands_sent, results_checked, PhaseCount, cycle_count);
    $display("raise %0d lower %0d stop %0d up %0d down %0d set %0d unused kinds %0d",
             kind_seen[KindRaise], kind_seen[KindLower], kind_seen[KindStop],
             kind_seen[KindTierUp], kind_seen[KindTierDown], kind_seen[KindSetTier],
             kind_seen[KindSpare6] + kind_seen[KindSpare7]);
    if (errors == 0 && setpoint_q.size() == 0) begin
      $display("tiered_lift_setpoint_manager_unit test passed");
    end else begin
      $display("tiered_lift_setpoint_manager_unit test failed");
    end
    $finish;
  end

endmodule
